### design/emar_pkg.sv
// shared constants, types and landmark pair table for the aspect ratio block
`default_nettype none
package emar_pkg;
	localparam int LANDMARK_COUNT = 68;
	localparam int COORD_BITS     = 13;
	localparam int FRAC_BITS      = 16;
	localparam int DIST_FRAC      = 8;
	localparam int OUT_W          = 24;
	localparam int IDX_W          = 7;
	localparam int ADDR_W         = $clog2(LANDMARK_COUNT);
	localparam int PAIR_COUNT     = 9;
	localparam int PAIR_W         = $clog2(PAIR_COUNT);
	localparam int DIFF_W         = COORD_BITS + 1;
	localparam int D2_W           = 2 * DIFF_W + 1;
	localparam int RAD_W          = ((D2_W + 2 * DIST_FRAC + 1) / 2) * 2;
	localparam int ROOT_W         = RAD_W / 2;
	localparam int DEN_W          = ROOT_W + 1;
	localparam int NUM_W          = ROOT_W + 1 + FRAC_BITS;
	localparam logic [OUT_W-1:0] OUT_MAX = {OUT_W{1'b1}};
	localparam logic [OUT_W-1:0] EAR_THRESHOLD_RESET = OUT_W'(13107);
	localparam logic [2:0] REG_EAR_THRESHOLD = 3'd0;

	typedef enum logic [3:0] {
		ST_IDLE, ST_RDA, ST_RDB, ST_DIFF, ST_MUL, ST_SQS, ST_SQRT,
		ST_DIVS, ST_DIV, ST_OUT
	} state_t;

	typedef struct packed {
		logic [ADDR_W-1:0] a;
		logic [ADDR_W-1:0] b;
	} pair_t;

	// eyes first (v1, v2, h per eye), then the mouth
	function automatic pair_t pair_of(input logic [PAIR_W-1:0] k);
		pair_t p;
		case (k)
			PAIR_W'(0): p = '{ADDR_W'(37), ADDR_W'(41)};
			PAIR_W'(1): p = '{ADDR_W'(38), ADDR_W'(40)};
			PAIR_W'(2): p = '{ADDR_W'(36), ADDR_W'(39)};
			PAIR_W'(3): p = '{ADDR_W'(43), ADDR_W'(47)};
			PAIR_W'(4): p = '{ADDR_W'(44), ADDR_W'(46)};
			PAIR_W'(5): p = '{ADDR_W'(42), ADDR_W'(45)};
			PAIR_W'(6): p = '{ADDR_W'(62), ADDR_W'(66)};
			PAIR_W'(7): p = '{ADDR_W'(60), ADDR_W'(64)};
			PAIR_W'(8): p = '{ADDR_W'(61), ADDR_W'(65)};
			default:    p = '{ADDR_W'(0), ADDR_W'(0)};
		endcase
		return p;
	endfunction
endpackage
`default_nettype wire

### design/emar_ram.sv
// generic single port ram with registered read
`default_nettype none
module emar_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule
`default_nettype wire

### design/emar_sqrt.sv
// bit-serial integer square root, one root bit per cycle
`default_nettype none
module emar_sqrt import emar_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [RAD_W-1:0]  radicand,
	output logic                   done,
	output logic      [ROOT_W-1:0] root
);
	localparam int R_W   = ROOT_W + 3;
	localparam int CNT_W = $clog2(ROOT_W + 1);

	logic [RAD_W-1:0]  n_q;
	logic [R_W-1:0]    r_q;
	logic [ROOT_W-1:0] q_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              run_q;
	logic              done_q;
	logic [R_W-1:0]    r2;
	logic [R_W-1:0]    trial;
	logic              fits;

	assign r2    = {r_q[R_W-3:0], n_q[RAD_W-1 -: 2]};
	assign trial = R_W'({q_q, 2'b01});
	assign fits  = r2 >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CNT_W'(ROOT_W);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q <= radicand;
			r_q <= '0;
			q_q <= '0;
		end else if (run_q) begin
			n_q <= {n_q[RAD_W-3:0], 2'b00};
			r_q <= fits ? r2 - trial : r2;
			q_q <= {q_q[ROOT_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign root = q_q;
endmodule
`default_nettype wire

### design/emar_div.sv
// bit-serial restoring divider, one quotient bit per cycle
`default_nettype none
module emar_div import emar_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [NUM_W-1:0] num,
	input  wire logic [DEN_W-1:0] den,
	output logic                  done,
	output logic      [NUM_W-1:0] quot
);
	localparam int R_W   = DEN_W + 1;
	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] n_q;
	logic [DEN_W-1:0] d_q;
	logic [R_W-1:0]   r_q;
	logic [NUM_W-1:0] q_q;
	logic [CNT_W-1:0] cnt_q;
	logic             run_q;
	logic             done_q;
	logic [R_W-1:0]   r2;
	logic             fits;

	assign r2   = {r_q[R_W-2:0], n_q[NUM_W-1]};
	assign fits = r2 >= R_W'(d_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CNT_W'(NUM_W);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q <= num;
			d_q <= den;
			r_q <= '0;
			q_q <= '0;
		end else if (run_q) begin
			n_q <= {n_q[NUM_W-2:0], 1'b0};
			r_q <= fits ? r2 - R_W'(d_q) : r2;
			q_q <= {q_q[NUM_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quot = q_q;
endmodule
`default_nettype wire

### design/eye_mouth_aspect_ratio.sv
// top level: landmark store, distance and ratio sequencer, register port
// a point that is not last leaves the sequencer idle; in_stall stays low while idle
// a last point starts the face: 9 distances, each with a bit-serial root,
// then 3 ratios, each with a bit-serial divide;
// ST_OUT then loads the result beat, waiting while an earlier beat is still stalled
// arst_n clears the sequencer, output valid and threshold (0.20); the point store is kept
`default_nettype none
module eye_mouth_aspect_ratio import emar_pkg::*; (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic        [IDX_W-1:0]      landmark_index,
	input  wire logic signed [COORD_BITS-1:0] point_x,
	input  wire logic signed [COORD_BITS-1:0] point_y,
	input  wire logic                         last_point,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic             [OUT_W-1:0]      eye_ratio,
	output logic             [OUT_W-1:0]      mouth_ratio,
	output logic                              drowsy,
	output logic                              eye_invalid,
	output logic                              mouth_invalid,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic        [2:0]            paddr,
	input  wire logic        [31:0]           pwdata,
	output logic             [31:0]           prdata,
	output logic                              pready
);
	state_t state_q, state_d;

	logic [OUT_W-1:0]  thr_q;
	logic              in_acc;
	logic              ram_we;
	logic [ADDR_W-1:0] ram_addr;
	logic [2*COORD_BITS-1:0] ram_rdata;
	logic [2*COORD_BITS-1:0] pa_q;
	logic [PAIR_W-1:0] pair_q;
	logic [1:0]        rat_cnt_q;
	pair_t             pair;
	logic [DIFF_W-1:0] dx_q, dy_q;
	logic [D2_W-1:0]   d2_q;
	logic signed [DIFF_W-1:0] ex, ey;
	logic [ROOT_W-1:0] dist_q [PAIR_COUNT];
	logic [NUM_W-1:0]  rat_q [3];
	logic              bad_q [3];
	logic              sq_start, sq_done, dv_start, dv_done;
	logic [ROOT_W-1:0] root;
	logic [NUM_W-1:0]  quot;
	logic [NUM_W:0]    ear_sum;
	logic [NUM_W-1:0]  ear_full;
	logic [OUT_W-1:0]  ear_sat, mar_sat;
	logic              ear_bad;
	logic              out_free;
	logic              out_load;

	assign pready = 1'b1;
	assign prdata = (paddr == REG_EAR_THRESHOLD) ? 32'(thr_q) : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= EAR_THRESHOLD_RESET;
		end else if (psel && penable && pwrite && paddr == REG_EAR_THRESHOLD) begin
			thr_q <= pwdata[OUT_W-1:0];
		end
	end

	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign pair     = pair_of(pair_q);
	assign ram_we   = in_acc && (32'(landmark_index) < LANDMARK_COUNT);

	always_comb begin
		case (state_q)
			ST_RDA:  ram_addr = pair.a;
			ST_RDB:  ram_addr = pair.b;
			default: ram_addr = landmark_index[ADDR_W-1:0];
		endcase
	end

	emar_ram #(.WIDTH(2 * COORD_BITS), .DEPTH(LANDMARK_COUNT)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata ({point_x, point_y}),
		.rdata (ram_rdata)
	);

	emar_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sq_start),
		.radicand (RAD_W'({d2_q, {(2 * DIST_FRAC){1'b0}}})),
		.done     (sq_done),
		.root     (root)
	);

	// operands always sit at the head of the distance line
	emar_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (dv_start),
		.num    ({(DEN_W)'(dist_q[0]) + DEN_W'(dist_q[1]), {FRAC_BITS{1'b0}}}),
		.den    ({dist_q[2], 1'b0}),
		.done   (dv_done),
		.quot   (quot)
	);

	assign out_free = !out_valid || !out_stall;

	always_comb begin
		state_d  = state_q;
		sq_start = 1'b0;
		dv_start = 1'b0;
		out_load = 1'b0;
		case (state_q)
			ST_IDLE: if (in_acc && last_point) state_d = ST_RDA;
			ST_RDA:  state_d = ST_RDB;
			ST_RDB:  state_d = ST_DIFF;
			ST_DIFF: state_d = ST_MUL;
			ST_MUL:  state_d = ST_SQS;
			ST_SQS: begin
				sq_start = 1'b1;
				state_d  = ST_SQRT;
			end
			ST_SQRT: if (sq_done) begin
				state_d = (pair_q == PAIR_W'(PAIR_COUNT - 1)) ? ST_DIVS : ST_RDA;
			end
			ST_DIVS: begin
				dv_start = 1'b1;
				state_d  = ST_DIV;
			end
			ST_DIV: if (dv_done) begin
				state_d = (rat_cnt_q == 2'd2) ? ST_OUT : ST_DIVS;
			end
			ST_OUT: if (out_free) begin
				out_load = 1'b1;
				state_d  = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			pair_q    <= '0;
			rat_cnt_q <= '0;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE) begin
				pair_q    <= '0;
				rat_cnt_q <= '0;
			end
			if (state_q == ST_SQRT && sq_done) pair_q <= pair_q + 1'b1;
			if (state_q == ST_DIV && dv_done) rat_cnt_q <= rat_cnt_q + 1'b1;
			if (out_load) out_valid <= 1'b1;
			else if (out_valid && !out_stall) out_valid <= 1'b0;
		end
	end

	assign ex = DIFF_W'(signed'(pa_q[2*COORD_BITS-1 -: COORD_BITS]))
		- DIFF_W'(signed'(ram_rdata[2*COORD_BITS-1 -: COORD_BITS]));
	assign ey = DIFF_W'(signed'(pa_q[COORD_BITS-1:0]))
		- DIFF_W'(signed'(ram_rdata[COORD_BITS-1:0]));

	always_ff @(posedge clk) begin
		if (state_q == ST_RDB) pa_q <= ram_rdata;
		if (state_q == ST_DIFF) begin
			dx_q <= ex[DIFF_W-1] ? DIFF_W'(-ex) : DIFF_W'(ex);
			dy_q <= ey[DIFF_W-1] ? DIFF_W'(-ey) : DIFF_W'(ey);
		end
		if (state_q == ST_MUL) begin
			d2_q <= D2_W'(dx_q) * D2_W'(dx_q) + D2_W'(dy_q) * D2_W'(dy_q);
		end
		// distance line fills from the top, drains three per ratio
		if (state_q == ST_SQRT && sq_done) begin
			for (int i = 0; i < PAIR_COUNT - 1; i++) dist_q[i] <= dist_q[i+1];
			dist_q[PAIR_COUNT-1] <= root;
		end
		if (state_q == ST_DIV && dv_done) begin
			for (int i = 0; i < PAIR_COUNT - 3; i++) dist_q[i] <= dist_q[i+3];
			for (int i = 0; i < 2; i++) begin
				rat_q[i] <= rat_q[i+1];
				bad_q[i] <= bad_q[i+1];
			end
			rat_q[2] <= quot;
			bad_q[2] <= (dist_q[2] == '0);
		end
		if (out_load) begin
			eye_ratio     <= ear_bad ? '0 : ear_sat;
			mouth_ratio   <= bad_q[2] ? '0 : mar_sat;
			drowsy        <= !ear_bad && (ear_sat < thr_q);
			eye_invalid   <= ear_bad;
			mouth_invalid <= bad_q[2];
		end
	end

	assign ear_bad  = bad_q[0] || bad_q[1];
	assign ear_sum  = (NUM_W + 1)'(rat_q[0]) + (NUM_W + 1)'(rat_q[1]);
	assign ear_full = ear_sum[NUM_W:1];
	assign ear_sat  = (ear_full > NUM_W'(OUT_MAX)) ? OUT_MAX : ear_full[OUT_W-1:0];
	assign mar_sat  = (rat_q[2] > NUM_W'(OUT_MAX)) ? OUT_MAX : rat_q[2][OUT_W-1:0];

`ifndef SYNTHESIS
	a_eye_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && eye_invalid |-> eye_ratio == '0 && !drowsy)
		else $error("invalid eye ratio not zero");
	a_mouth_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && mouth_invalid |-> mouth_ratio == '0)
		else $error("invalid mouth ratio not zero");
	a_sqrt_owner: assert property (@(posedge clk) disable iff (!arst_n)
		sq_done |-> state_q == ST_SQRT)
		else $error("root finished outside its wait state");
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> !(out_valid && out_stall))
		else $error("result beat overwritten");
`endif
endmodule
`default_nettype wire
